/* sv/trial_frame_timer_core_defines.svh */
// Assertion macros used by the checker file of the frame timer.
`ifndef TRIAL_FRAME_TIMER_CORE_DEFINES_SVH
`define TRIAL_FRAME_TIMER_CORE_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted
`define TFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define TFT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* sv/tft_pkg.sv */
`default_nettype none
package tft_pkg;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned CntW   = 16;  // internal trial/frame counter width, 8..32
  localparam int unsigned OutCntW = 16; // reported counter width
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OutUserW = 4;
  localparam int unsigned OutDataW = 2 * OutCntW + 2 * TimeW;

  // Register reset values
  localparam logic [TimeW-1:0] StartDelayRst    = 32'd50000;
  localparam logic [TimeW-1:0] FrameIntervalRst = 32'd30000;
  localparam logic [TimeW-1:0] TrialDurationRst = 32'd60000000;

  // Item kinds
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_TRIG   = 2'd1,
    FUNC_TOGGLE = 2'd2
  } func_e;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_START_DELAY    = 2'd0,
    REG_FRAME_INTERVAL = 2'd1,
    REG_TRIAL_DURATION = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] start_delay;
    logic [TimeW-1:0] frame_interval;
    logic [TimeW-1:0] trial_duration;
  } tft_cfg_t;

  typedef struct packed {
    logic               valid;
    logic               trigger_pulse;
    logic               trial_stopped;
    logic               frame_pulse;
    logic               trial_running;
    logic [OutCntW-1:0] trial_index;
    logic [OutCntW-1:0] frames_done;
    logic [TimeW-1:0]   elapsed;
    logic [TimeW-1:0]   frame_gap;
  } tft_res_t;

endpackage
`default_nettype wire

/* sv/tft_cfg_regs.sv */
`default_nettype none
module tft_cfg_regs
  import tft_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [TimeW-1:0]   cfg_wdata_i,
  output tft_cfg_t                cfg_o
);

  tft_cfg_t cfg_q;

  // Register file; an unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_delay    <= StartDelayRst;
      cfg_q.frame_interval <= FrameIntervalRst;
      cfg_q.trial_duration <= TrialDurationRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_START_DELAY:    cfg_q.start_delay    <= cfg_wdata_i;
        REG_FRAME_INTERVAL: cfg_q.frame_interval <= cfg_wdata_i;
        REG_TRIAL_DURATION: cfg_q.trial_duration <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* sv/tft_engine.sv */
`default_nettype none
module tft_engine
  import tft_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tft_cfg_t         cfg_i,
  input  wire logic             step_i,   // item in the input stage is consumed
  input  wire logic [FuncW-1:0] func_i,
  input  wire logic [TimeW-1:0] now_i,
  output tft_res_t              res_o
);

  logic             running_q, running_d;
  logic [CntW-1:0]  trial_cnt_q, trial_cnt_d;
  logic [CntW-1:0]  frame_cnt_q, frame_cnt_d;
  logic [TimeW-1:0] start_time_q, start_time_d;
  logic [TimeW-1:0] last_frame_q, last_frame_d;

  logic [TimeW-1:0] frame_due, stop_due, elapsed_now, gap_now;
  logic             frame_hit, stop_hit;
  logic             trig, stopped, frame;
  logic [TimeW-1:0] elapsed, gap;

  // Deadline sums and differences, all wrapping
  assign frame_due   = last_frame_q + cfg_i.frame_interval;
  assign stop_due    = start_time_q + cfg_i.trial_duration;
  assign elapsed_now = now_i - start_time_q;
  assign gap_now     = now_i - last_frame_q;
  assign frame_hit   = now_i > frame_due;
  assign stop_hit    = now_i > stop_due;

  // Next state and result for the current item
  always_comb begin
    running_d    = running_q;
    trial_cnt_d  = trial_cnt_q;
    frame_cnt_d  = frame_cnt_q;
    start_time_d = start_time_q;
    last_frame_d = last_frame_q;
    trig         = 1'b0;
    stopped      = 1'b0;
    frame        = 1'b0;
    elapsed      = '0;
    gap          = '0;
    case (func_e'(func_i))
      FUNC_TICK: begin
        if (running_q) begin
          if (frame_hit) begin
            frame        = 1'b1;
            frame_cnt_d  = frame_cnt_q + 1'b1;
            gap          = gap_now;
            last_frame_d = now_i;
          end
          if (stop_hit) begin
            trig      = 1'b1;
            stopped   = 1'b1;
            running_d = 1'b0;
          end
          elapsed = elapsed_now;
        end
      end
      FUNC_TRIG, FUNC_TOGGLE: begin
        if (running_q) begin
          // toggle stops a running trial, a trigger is ignored
          if (func_e'(func_i) == FUNC_TOGGLE) begin
            trig      = 1'b1;
            stopped   = 1'b1;
            running_d = 1'b0;
            elapsed   = elapsed_now;
          end
        end else begin
          trig         = 1'b1;
          running_d    = 1'b1;
          trial_cnt_d  = trial_cnt_q + 1'b1;
          start_time_d = now_i;
          last_frame_d = now_i + cfg_i.start_delay;
          frame_cnt_d  = '0;
        end
      end
      default: ;
    endcase
  end

  // Trial state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      trial_cnt_q  <= '0;
      frame_cnt_q  <= '0;
      start_time_q <= '0;
      last_frame_q <= '0;
    end else if (step_i) begin
      running_q    <= running_d;
      trial_cnt_q  <= trial_cnt_d;
      frame_cnt_q  <= frame_cnt_d;
      start_time_q <= start_time_d;
      last_frame_q <= last_frame_d;
    end
  end

  // Result, only when something happened
  always_comb begin
    res_o.valid         = step_i && (trig || frame);
    res_o.trigger_pulse = trig;
    res_o.trial_stopped = stopped;
    res_o.frame_pulse   = frame;
    res_o.trial_running = running_d;
    res_o.trial_index   = OutCntW'(trial_cnt_d);
    res_o.frames_done   = OutCntW'(frame_cnt_d);
    res_o.elapsed       = elapsed;
    res_o.frame_gap     = gap;
  end

endmodule
`default_nettype wire

/* sv/tft_out_reg.sv */
`default_nettype none
module tft_out_reg
  import tft_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tft_res_t            res_i,
  output logic                     free_o,   // register can take a result this cycle
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic [OutUserW-1:0]      m_axis_tuser
);

  logic                valid_q, valid_d;
  logic [OutDataW-1:0] data_q;
  logic [OutUserW-1:0] user_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      data_q <= {res_i.frame_gap, res_i.elapsed, res_i.frames_done, res_i.trial_index};
      user_q <= {res_i.trial_running, res_i.frame_pulse, res_i.trial_stopped,
                 res_i.trigger_pulse};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

endmodule
`default_nettype wire

/* sv/trial_frame_timer_core.sv */
// Trial and frame timing generator.
// Input stream s_axis: tuser carries the item kind (tick, start trigger,
// start/stop toggle), tdata the 32-bit timestamp. Configuration is a plain
// write port (start delay, frame interval, trial duration); write it only
// while the block is idle.
// Output stream m_axis: one item per input that starts or stops a trial or
// emits a frame; inputs with no event produce nothing.
// Throughput: one input item per clock while the receiver does not stall. The
// trial state is updated by one pass of adds and compares between the input
// register and the output register, so an item sees the state left by the
// item before it. A taken input waits in the input register, and its result
// is loaded into the output register once that register can take it.
// When the receiver stalls, the output register holds its item, the item in
// the input register waits and s_axis_tready falls until space frees.
// Reset clears the trial state (idle, counters and times zero), loads the
// register defaults and empties both registers.
`default_nettype none
module trial_frame_timer_core
  import tft_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [TimeW-1:0]    cfg_wdata_i,
  // input items
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [TimeW-1:0]    s_axis_tdata,  // [31:0] now
  input  wire logic [FuncW-1:0]    s_axis_tuser,  // [1:0] func
  // result items
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,  // [15:0] trial_index, [31:16] frames_done,
                                                  // [63:32] elapsed, [95:64] frame_gap
  output logic [OutUserW-1:0]      m_axis_tuser   // [0] trigger_pulse, [1] trial_stopped,
                                                  // [2] frame_pulse, [3] trial_running
);

  tft_cfg_t cfg;
  tft_res_t res;

  logic             in_valid_q;
  logic [FuncW-1:0] in_func_q;
  logic [TimeW-1:0] in_now_q;
  logic             out_free;
  logic             step;

  // The staged item moves on when the output register can take its result
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= s_axis_tuser;
      in_now_q  <= s_axis_tdata;
    end
  end

  tft_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tft_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .func_i (in_func_q),
    .now_i  (in_now_q),
    .res_o  (res)
  );

  tft_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire

/* sv/tft_checker.sv */
`default_nettype none
`include "trial_frame_timer_core_defines.svh"
module tft_checker
  import tft_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic [OutUserW-1:0] m_axis_tuser
);

  // Every result carries an event
  `TFT_ASSERT(a_has_event, m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tuser[2]), "result without event")

  // A stop leaves the trial idle; a start leaves it running with no frames and zero elapsed
  `TFT_ASSERT(a_stop_idle, (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] && !m_axis_tuser[3]), "stop event inconsistent")
  `TFT_ASSERT(a_start_clean, (m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1]) |-> (m_axis_tuser[3] && m_axis_tdata[31:16] == '0 && m_axis_tdata[63:32] == '0 && !m_axis_tuser[2]), "start event inconsistent")

  // Frame gap is reported only with a frame
  `TFT_ASSERT(a_gap_zero, (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata[95:64] == '0), "gap without frame")

  // A stalled result holds
  `TFT_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind trial_frame_timer_core tft_checker u_tft_checker (.*);
`default_nettype wire
